// ===== rtl/core/jsesc_pkg.sv =====
// Shared types, constants and the lookup table of the JSON string escaper.
package jsesc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_WIDTH = 16;
    localparam int SUM_WIDTH = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
    localparam int PIECE_MAX = 6;
    localparam int LEN_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_OPEN = 2'd1;
    localparam logic [1:0] CMD_BYTE = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(256);

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [PIECE_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      present;
        logic                      wvalid;
    } piece_t;

    localparam logic [15:0] CP850_MAP [128] = '{
        16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
        16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
        16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
        16'h00ff, 16'h00d6, 16'h00dc, 16'h00f8, 16'h00a3, 16'h00d8, 16'h00d7, 16'h0192,
        16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
        16'h00bf, 16'h00ae, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00c1, 16'h00c2, 16'h00c0,
        16'h00a9, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h00a2, 16'h00a5, 16'h2510,
        16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h00e3, 16'h00c3,
        16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h00a4,
        16'h00f0, 16'h00d0, 16'h00ca, 16'h00cb, 16'h00c8, 16'h0131, 16'h00cd, 16'h00ce,
        16'h00cf, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h00a6, 16'h00cc, 16'h2580,
        16'h00d3, 16'h00df, 16'h00d4, 16'h00d2, 16'h00f5, 16'h00d5, 16'h00b5, 16'h00fe,
        16'h00de, 16'h00da, 16'h00db, 16'h00d9, 16'h00fd, 16'h00dd, 16'h00af, 16'h00b4,
        16'h00ad, 16'h00b1, 16'h2017, 16'h00be, 16'h00b6, 16'h00a7, 16'h00f7, 16'h00b8,
        16'h00b0, 16'h00a8, 16'h00b7, 16'h00b9, 16'h00b3, 16'h00b2, 16'h25a0, 16'h00a0
    };

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'h0, nib};
        end
        else
        begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/jsesc_front.sv =====
// Front end: accepts words, builds the escape piece and checks it against the capacity.
module jsesc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [15:0]           cfg_data,
    input  logic                  push,
    input  logic [1:0]            cmd,
    input  logic [7:0]            char_byte,
    input  logic                  cp850_mode,
    output jsesc_pkg::piece_t     piece
);

    logic [jsesc_pkg::CAP_WIDTH-1:0]   cap_reg;
    logic [jsesc_pkg::COUNT_WIDTH-1:0] used_reg;
    logic [jsesc_pkg::COUNT_WIDTH-1:0] used_next;
    logic                              valid_reg;
    logic                              valid_next;

    logic [jsesc_pkg::PIECE_MAX-1:0][7:0] bytes;
    logic [jsesc_pkg::LEN_W-1:0]          len;
    logic [15:0]                          code;
    logic [jsesc_pkg::SUM_WIDTH-1:0]      sum;
    logic                                 fits;

    always_comb
    begin
        bytes = '0;
        code = jsesc_pkg::CP850_MAP[char_byte[6:0]];
        if (char_byte < jsesc_pkg::CTRL_LIMIT)
        begin
            code = {8'h00, char_byte};
        end
        if (cmd != jsesc_pkg::CMD_BYTE)
        begin
            bytes[0] = jsesc_pkg::CHAR_QUOTE;
            len = jsesc_pkg::LEN_W'(1);
        end
        else if (char_byte == jsesc_pkg::CHAR_QUOTE || char_byte == jsesc_pkg::CHAR_BSLASH)
        begin
            bytes[0] = jsesc_pkg::CHAR_BSLASH;
            bytes[1] = char_byte;
            len = jsesc_pkg::LEN_W'(2);
        end
        else if (char_byte < jsesc_pkg::CTRL_LIMIT || (cp850_mode && char_byte[7]))
        begin
            bytes[0] = jsesc_pkg::CHAR_BSLASH;
            bytes[1] = jsesc_pkg::CHAR_U;
            bytes[2] = jsesc_pkg::hex_char(code[15:12]);
            bytes[3] = jsesc_pkg::hex_char(code[11:8]);
            bytes[4] = jsesc_pkg::hex_char(code[7:4]);
            bytes[5] = jsesc_pkg::hex_char(code[3:0]);
            len = jsesc_pkg::LEN_W'(6);
        end
        else
        begin
            bytes[0] = char_byte;
            len = jsesc_pkg::LEN_W'(1);
        end
    end

    assign sum = jsesc_pkg::SUM_WIDTH'(used_reg) + jsesc_pkg::SUM_WIDTH'(len);
    assign fits = (sum < jsesc_pkg::SUM_WIDTH'(cap_reg))
        && (sum <= jsesc_pkg::SUM_WIDTH'({jsesc_pkg::COUNT_WIDTH{1'b1}}));

    always_comb
    begin
        used_next = used_reg;
        valid_next = valid_reg;
        piece.bytes = '0;
        piece.len = jsesc_pkg::LEN_W'(1);
        piece.present = 1'b0;
        if (cmd == jsesc_pkg::CMD_START)
        begin
            used_next = '0;
            valid_next = (cap_reg != '0);
        end
        else if (!valid_reg)
        begin
            valid_next = 1'b0;
        end
        else if (cmd == jsesc_pkg::CMD_BYTE && char_byte == 8'h00)
        begin
            valid_next = 1'b1;
        end
        else if (fits)
        begin
            used_next = sum[jsesc_pkg::COUNT_WIDTH-1:0];
            piece.bytes = bytes;
            piece.len = len;
            piece.present = 1'b1;
        end
        else
        begin
            valid_next = 1'b0;
        end
        piece.wvalid = valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= jsesc_pkg::CAP_RESET;
            used_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (push)
            begin
                used_reg <= used_next;
                valid_reg <= valid_next;
            end
        end
    end

endmodule

// ===== rtl/core/jsesc_queue.sv =====
// Short queue of escape pieces between the front end and the byte sequencer.
module jsesc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsesc_pkg::piece_t wr_data,
    input  logic              pop,
    output jsesc_pkg::piece_t rd_data,
    output logic              full,
    output logic              not_empty
);

    jsesc_pkg::piece_t                 mem_reg [jsesc_pkg::QUEUE_DEPTH];
    logic [jsesc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [jsesc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [jsesc_pkg::QPTR_W:0]        count_reg;

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full = (count_reg == (jsesc_pkg::QPTR_W + 1)'(jsesc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + jsesc_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + jsesc_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (jsesc_pkg::QPTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (jsesc_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/jsesc_back.sv =====
// Back end: sends the bytes of each queued piece as one result word per cycle while res_stall is low.
module jsesc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  jsesc_pkg::piece_t rd_data,
    input  logic              not_empty,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [7:0]        out_byte,
    output logic              byte_present,
    output logic              writer_valid,
    output logic              last_of_run
);

    jsesc_pkg::piece_t            piece_reg;
    logic [jsesc_pkg::LEN_W-1:0]  idx_reg;
    logic [jsesc_pkg::LEN_W-1:0]  idx_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         fire;

    assign res_valid = busy_reg;
    assign out_byte = piece_reg.bytes[idx_reg];
    assign byte_present = piece_reg.present;
    assign writer_valid = piece_reg.wvalid;
    assign last_of_run = (idx_reg == piece_reg.len - jsesc_pkg::LEN_W'(1));
    assign fire = busy_reg && !res_stall;
    assign pop = not_empty && (!busy_reg || (fire && last_of_run));

    always_comb
    begin
        idx_next = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next = '0;
            busy_next = 1'b1;
        end
        else if (fire && last_of_run)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + jsesc_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            piece_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/core/json_string_escaper_cp850_core.sv =====
// Top level of the JSON string escaper with bounded output and CP850 mapping.
// The front end takes one command word per cycle while its four-entry piece queue has room,
// escapes it and checks it against the capacity from cfg_data; the back end sends one result
// word per cycle while res_stall is low, each word giving one result word per piece byte: one
// for a command that emits nothing or one byte, two for an escaped quote or backslash, six
// for a \u escape. A piece is registered in the queue, then in the back-end piece register.
// Capacity writes on cfg_data are always taken and should be made while the block is idle.
module json_string_escaper_cp850_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_byte,
    input  logic        cp850_mode,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        byte_present,
    output logic        writer_valid,
    output logic        last_of_run
);

    jsesc_pkg::piece_t wr_piece;
    jsesc_pkg::piece_t rd_piece;
    logic              push;
    logic              pop;
    logic              full;
    logic              not_empty;

    assign cfg_ready = 1'b1;
    assign item_stall = full;
    assign push = item_valid && !full;

    jsesc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push       (push),
        .cmd        (cmd),
        .char_byte  (char_byte),
        .cp850_mode (cp850_mode),
        .piece      (wr_piece)
    );

    jsesc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_piece),
        .pop       (pop),
        .rd_data   (rd_piece),
        .full      (full),
        .not_empty (not_empty)
    );

    jsesc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_data      (rd_piece),
        .not_empty    (not_empty),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .writer_valid (writer_valid),
        .last_of_run  (last_of_run)
    );

endmodule
